// ===== sv/tea_pkg.sv =====
`default_nettype none

package tea_pkg;

  // Round count limit and the derived width of the round counter.
  localparam int unsigned MAX_ROUNDS = 64;
  localparam int unsigned RND_W      = $clog2(MAX_ROUNDS + 1);

  // Field widths fixed by the register and stream formats.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ROUND_W  = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_A     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_B     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_C     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_D     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_SWAP = 3'd5;

  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 7'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new block and start the round sequence
    logic step;     // run one half-round
    logic capture;  // copy the finished block into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rounds_zero;
  } dp_status_t;

  function automatic logic [WORD_W-1:0] byte_rev(input logic [WORD_W-1:0] w);
    byte_rev = {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // TEA round function: ((x << 4) + k0) ^ (x + s) ^ ((x >> 5) + k1).
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                input logic [WORD_W-1:0] k0,
                                                input logic [WORD_W-1:0] k1,
                                                input logic [WORD_W-1:0] s);
    tea_mix = ((x << 4) + k0) ^ (x + s) ^ ((x >> 5) + k1);
  endfunction

endpackage

`default_nettype wire

// ===== sv/tea_ctrl.sv =====
`default_nettype none

module tea_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  wire tea_pkg::dp_status_t status_i,
  output tea_pkg::dp_cmd_t     cmd_o
);

  tea_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tea_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      tea_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tea_pkg::ST_RUN;
        end
      end
      tea_pkg::ST_RUN: begin
        if (status_i.rounds_zero) begin
          state_d = tea_pkg::ST_FINISH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      tea_pkg::ST_FINISH: begin
        // Hand the block over once the output register is free.
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = tea_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tea_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tea_datapath.sv =====
`default_nettype none

module tea_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [tea_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [tea_pkg::WORD_W-1:0]           cfg_data_i,
  input  wire                                  kind_i,
  input  wire  [tea_pkg::WORD_W-1:0]           word_left_i,
  input  wire  [tea_pkg::WORD_W-1:0]           word_right_i,
  input  wire tea_pkg::dp_cmd_t                cmd_i,
  output tea_pkg::dp_status_t                  status_o,
  output logic [tea_pkg::WORD_W-1:0]           result_left_o,
  output logic [tea_pkg::WORD_W-1:0]           result_right_o
);

  // Configuration registers.
  logic [tea_pkg::WORD_W-1:0]  key_a_q, key_b_q, key_c_q, key_d_q;
  logic [tea_pkg::ROUND_W-1:0] rounds_cfg_q;
  logic                        swap_q;

  // Working state.
  logic [tea_pkg::WORD_W-1:0]  y_q, y_d, z_q, z_d, sum_q, sum_d;
  logic [tea_pkg::RND_W-1:0]   rounds_q, rounds_d;
  logic                        phase_q, phase_d;
  logic                        dec_q, dec_d;
  logic [tea_pkg::WORD_W-1:0]  res_l_q, res_r_q;

  logic [tea_pkg::WORD_W-1:0]  key_a, key_b, key_c, key_d;
  logic [tea_pkg::WORD_W-1:0]  in_l, in_r;
  logic [tea_pkg::ROUND_W-1:0] n_sat;
  logic                        x_is_z;
  logic [tea_pkg::WORD_W-1:0]  mix_x, mix_k0, mix_k1, mix_f, tgt, tgt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q      <= '0;
      key_b_q      <= '0;
      key_c_q      <= '0;
      key_d_q      <= '0;
      rounds_cfg_q <= tea_pkg::ROUNDS_RESET;
      swap_q       <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tea_pkg::CFG_KEY_A:     key_a_q      <= cfg_data_i;
        tea_pkg::CFG_KEY_B:     key_b_q      <= cfg_data_i;
        tea_pkg::CFG_KEY_C:     key_c_q      <= cfg_data_i;
        tea_pkg::CFG_KEY_D:     key_d_q      <= cfg_data_i;
        tea_pkg::CFG_ROUNDS:    rounds_cfg_q <= cfg_data_i[tea_pkg::ROUND_W-1:0];
        tea_pkg::CFG_BYTE_SWAP: swap_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign key_a = swap_q ? tea_pkg::byte_rev(key_a_q) : key_a_q;
  assign key_b = swap_q ? tea_pkg::byte_rev(key_b_q) : key_b_q;
  assign key_c = swap_q ? tea_pkg::byte_rev(key_c_q) : key_c_q;
  assign key_d = swap_q ? tea_pkg::byte_rev(key_d_q) : key_d_q;
  assign in_l  = swap_q ? tea_pkg::byte_rev(word_left_i) : word_left_i;
  assign in_r  = swap_q ? tea_pkg::byte_rev(word_right_i) : word_right_i;

  assign n_sat = (rounds_cfg_q > tea_pkg::ROUND_W'(tea_pkg::MAX_ROUNDS))
               ? tea_pkg::ROUND_W'(tea_pkg::MAX_ROUNDS) : rounds_cfg_q;

  // Encryption updates y then z; decryption updates z then y. The mix input
  // is the word that is not being updated, and keys a/b go with input z.
  assign x_is_z  = dec_q ? phase_q : !phase_q;
  assign mix_x   = x_is_z ? z_q : y_q;
  assign tgt     = x_is_z ? y_q : z_q;
  assign mix_k0  = x_is_z ? key_a : key_c;
  assign mix_k1  = x_is_z ? key_b : key_d;
  assign mix_f   = tea_pkg::tea_mix(mix_x, mix_k0, mix_k1, sum_q);
  assign tgt_new = dec_q ? (tgt - mix_f) : (tgt + mix_f);

  always_comb begin
    y_d      = y_q;
    z_d      = z_q;
    sum_d    = sum_q;
    rounds_d = rounds_q;
    phase_d  = phase_q;
    dec_d    = dec_q;
    if (cmd_i.load) begin
      y_d      = in_l;
      z_d      = in_r;
      dec_d    = kind_i;
      rounds_d = tea_pkg::RND_W'(n_sat);
      phase_d  = 1'b0;
      // Encryption runs with sum already advanced by one delta; decryption
      // starts at delta times the round count.
      sum_d    = kind_i ? (tea_pkg::TEA_DELTA * tea_pkg::WORD_W'(n_sat))
                        : tea_pkg::TEA_DELTA;
    end else if (cmd_i.step) begin
      if (x_is_z) begin
        y_d = tgt_new;
      end else begin
        z_d = tgt_new;
      end
      phase_d = !phase_q;
      if (phase_q) begin
        rounds_d = rounds_q - tea_pkg::RND_W'(1);
        sum_d    = dec_q ? (sum_q - tea_pkg::TEA_DELTA) : (sum_q + tea_pkg::TEA_DELTA);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounds_q <= '0;
      phase_q  <= 1'b0;
      dec_q    <= 1'b0;
    end else begin
      rounds_q <= rounds_d;
      phase_q  <= phase_d;
      dec_q    <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    z_q   <= z_d;
    sum_q <= sum_d;
    if (cmd_i.capture) begin
      res_l_q <= swap_q ? tea_pkg::byte_rev(y_q) : y_q;
      res_r_q <= swap_q ? tea_pkg::byte_rev(z_q) : z_q;
    end
  end

  assign status_o.rounds_zero = (rounds_q == '0);
  assign result_left_o        = res_l_q;
  assign result_right_o       = res_r_q;

endmodule

`default_nettype wire

// ===== sv/tea_block_cipher_unit.sv =====
`default_nettype none

// Channel     Direction  Handshake                      Payload
// s_axis      in         s_axis_tvalid_i/tready_o       tdata: word_left, word_right;
//                                                       tuser: kind
// m_axis      out        m_axis_tvalid_o/tready_i       tdata: result_left, result_right
// cfg         in         cfg_we_i (no wait)             cfg_idx_i, cfg_data_i
//
// A block runs N rounds of two half-rounds each, where N is the configured
// round count saturated at MAX_ROUNDS. The rounds run on the shared TEA mix
// unit, which runs one half-round per clock. The next input transfer is
// taken only once the previous block has gone into the output register.
// Reset is asynchronous and active low; it restores the register defaults
// (zero key, 32 rounds, no byte swap) and leaves the block idle.
// The result waits in an output register, so a new block is taken while the
// previous result still waits for its transfer; a finished block stalls
// until that register is free.

module tea_block_cipher_unit (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Configuration write port.
  input  wire                                cfg_we_i,
  input  wire  [tea_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [tea_pkg::WORD_W-1:0]         cfg_data_i,
  // Input stream.
  input  wire                                s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire  [2*tea_pkg::WORD_W-1:0]       s_axis_tdata_i,  // [31:0] word_left, [63:32] word_right
  input  wire                                s_axis_tuser_i,  // [0] kind: 0 encrypt, 1 decrypt
  // Output stream.
  output logic                               m_axis_tvalid_o,
  input  wire                                m_axis_tready_i,
  output logic [2*tea_pkg::WORD_W-1:0]       m_axis_tdata_o   // [31:0] result_left, [63:32] result_right
);

  tea_pkg::dp_cmd_t    cmd;
  tea_pkg::dp_status_t status;
  logic [tea_pkg::WORD_W-1:0] res_l, res_r;

  // The controller sequences load, the half-round steps and the hand-over
  // into the output register.
  tea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration registers, the working halves, the
  // round sum and counter, and the output register.
  tea_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (s_axis_tuser_i),
    .word_left_i    (s_axis_tdata_i[tea_pkg::WORD_W-1:0]),
    .word_right_i   (s_axis_tdata_i[2*tea_pkg::WORD_W-1:tea_pkg::WORD_W]),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_left_o  (res_l),
    .result_right_o (res_r)
  );

  assign m_axis_tdata_o = {res_r, res_l};

endmodule

`default_nettype wire

// ===== sim/tea_block_cipher_unit_tb.sv =====
`default_nettype none

// One 64-bit block as it travels on the streams.
typedef struct packed {
  logic [31:0] right_half;
  logic [31:0] left_half;
} tea_block_t;

// Result board for the TEA unit. It keeps its own copy of the key, the round
// count and the byte order, computes the block that each accepted input must
// turn into, and matches the blocks that leave the unit against that list.
class tea_result_board;

  logic [31:0]  key_words [4];
  logic [6:0]   round_setting;
  logic         net_order;
  tea_block_t   expected_blocks [$];
  int unsigned  fault_count;

  function new();
    key_words     = '{default: 32'h0};
    round_setting = tea_pkg::ROUNDS_RESET;
    net_order     = 1'b0;
    fault_count   = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] value);
    case (idx)
      tea_pkg::CFG_KEY_A:     key_words[0] = value;
      tea_pkg::CFG_KEY_B:     key_words[1] = value;
      tea_pkg::CFG_KEY_C:     key_words[2] = value;
      tea_pkg::CFG_KEY_D:     key_words[3] = value;
      tea_pkg::CFG_ROUNDS:    round_setting = value[6:0];
      tea_pkg::CFG_BYTE_SWAP: net_order = value[0];
      default: ;
    endcase
  endfunction

  // Reverses the bytes of a word when network byte order is selected.
  function logic [31:0] host_word(logic [31:0] w);
    if (!net_order) return w;
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function logic [31:0] round_term(logic [31:0] x, logic [31:0] ka, logic [31:0] kb,
                                   logic [31:0] s);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  function tea_block_t cipher_block(bit decrypt, logic [31:0] left, logic [31:0] right);
    logic [31:0] y, z, sum;
    logic [31:0] k [4];
    int unsigned cycles;
    tea_block_t  blk;
    y = host_word(left);
    z = host_word(right);
    for (int i = 0; i < 4; i++) k[i] = host_word(key_words[i]);
    cycles = (round_setting > tea_pkg::MAX_ROUNDS) ? tea_pkg::MAX_ROUNDS : round_setting;
    if (decrypt) begin
      sum = tea_pkg::TEA_DELTA * cycles;
      repeat (cycles) begin
        z = z - round_term(y, k[2], k[3], sum);
        y = y - round_term(z, k[0], k[1], sum);
        sum = sum - tea_pkg::TEA_DELTA;
      end
    end else begin
      sum = 32'h0;
      repeat (cycles) begin
        sum = sum + tea_pkg::TEA_DELTA;
        y = y + round_term(z, k[0], k[1], sum);
        z = z + round_term(y, k[2], k[3], sum);
      end
    end
    blk.left_half  = host_word(y);
    blk.right_half = host_word(z);
    return blk;
  endfunction

  function tea_block_t note_block(bit decrypt, logic [31:0] left, logic [31:0] right);
    tea_block_t blk;
    blk = cipher_block(decrypt, left, right);
    expected_blocks.push_back(blk);
    return blk;
  endfunction

  function void check_result(logic [63:0] data);
    tea_block_t want, got;
    got = data;
    if (expected_blocks.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("ERROR: unexpected result left %h right %h", got.left_half, got.right_half);
      return;
    end
    want = expected_blocks.pop_front();
    if (got.left_half !== want.left_half || got.right_half !== want.right_half) begin
      fault_count++;
      if (fault_count <= 10)
        $display("ERROR: result mismatch: expected left %h right %h, got left %h right %h",
                 want.left_half, want.right_half, got.left_half, got.right_half);
    end
  endfunction

  function int unsigned pending();
    return expected_blocks.size();
  endfunction

endclass

module tea_block_cipher_unit_tb;

  // The register map has two spare indexes; writes to them must be ignored.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam bit KIND_ENCRYPT = 1'b0;
  localparam bit KIND_DECRYPT = 1'b1;

  // Longest block: both half-rounds of every round at the saturated round count, plus load and capture.
  localparam int unsigned BLOCK_LATENCY = 2 * tea_pkg::MAX_ROUNDS + 2;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned IDLE_PERCENT  = 27;
  localparam int unsigned RANDOM_PHASES = 26;
  localparam int unsigned PHASE_BLOCKS  = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;

  // While set, neither the sender nor the receiver inserts idle cycles.
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;

  tea_result_board board;

  tea_block_cipher_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),  // [31:0] word_left, [63:32] word_right
    .s_axis_tuser_i  (s_axis_tuser_i),  // [0] kind
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)   // [31:0] result_left, [63:32] result_right
  );

  always #5 clk_i = ~clk_i;

  // Watchdog. A correct run stays far below this limit even with every block
  // at the saturated round count and the receiver stalling often.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tea_block_cipher_unit verification failed");
      $finish;
    end
  end

  // Output side. A transfer is taken from the values that stood before the
  // edge; the ready for the next cycle is then drawn at random, low in about
  // a quarter of the cycles unless the no-idle stretch is running.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      board.check_result(m_axis_tdata_o);
    end
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // One register write. The write enable stays high so that a batch of
  // writes runs back to back; the caller lowers it after the batch. The
  // board's copy changes at the same edge as the unit's register.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    board.write_reg(idx, value);
  endtask

  task automatic write_settings(input logic [31:0] ka, input logic [31:0] kb,
                                input logic [31:0] kc, input logic [31:0] kd,
                                input logic [6:0] rounds, input logic swap);
    write_reg(tea_pkg::CFG_KEY_A, ka);
    write_reg(tea_pkg::CFG_KEY_B, kb);
    write_reg(tea_pkg::CFG_KEY_C, kc);
    write_reg(tea_pkg::CFG_KEY_D, kd);
    // Upper data bits of the narrow registers are filled at random to show they are dropped.
    write_reg(tea_pkg::CFG_ROUNDS, {$urandom} << 7 | rounds);
    write_reg(tea_pkg::CFG_BYTE_SWAP, {$urandom} << 1 | swap);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one block and holds it until the unit takes it. The valid is left
  // high after the transfer so that the next block can follow without a gap;
  // it is only lowered when an idle cycle is drawn or the stream is drained.
  task automatic send_block(input bit decrypt, input logic [31:0] left,
                            input logic [31:0] right,
                            output tea_block_t predicted);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {right, left};
    s_axis_tuser_i  <= decrypt;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = board.note_block(decrypt, left, right);
  endtask

  // Stops offering blocks and waits until every result has left the unit, so
  // that the registers can be rewritten while it is idle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6:0] pick_rounds();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return 7'd65;
      4: return 7'd127;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  initial begin
    tea_block_t predicted;
    tea_block_t last_cipher;
    bit have_cipher;
    bit decrypt;

    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: zero key, 32 rounds, host byte order. Nothing is written
    // first, so these blocks check the register reset values as well.
    send_block(KIND_ENCRYPT, 32'h0000_0000, 32'h0000_0000, predicted);
    send_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, predicted);
    send_block(KIND_DECRYPT, 32'h0000_0000, 32'h0000_0000, predicted);
    send_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, predicted);
    drain();

    // Zero rounds pass the block through; the spare indexes must not disturb
    // any register.
    write_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 1'b0);
    @(posedge clk_i);
    write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(CFG_SPARE_HI, 32'h0000_0000);
    cfg_we_i <= 1'b0;
    send_block(KIND_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, predicted);
    send_block(KIND_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF, predicted);
    drain();

    // Zero rounds in network byte order: the two swaps cancel out.
    write_settings(32'h0, 32'h0, 32'h0, 32'h0, 7'd0, 1'b1);
    send_block(KIND_ENCRYPT, 32'h0011_2233, 32'h4455_6677, predicted);
    send_block(KIND_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, predicted);
    drain();

    // A single round with mixed key words in network order.
    write_settings(32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678, 32'h9ABC_DEF0, 7'd1, 1'b1);
    send_block(KIND_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, predicted);
    send_block(KIND_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, predicted);
    drain();

    // The largest round count that is run as given.
    write_settings(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'hFFFF_FFFF, 32'h0000_0001, 7'd64, 1'b0);
    send_block(KIND_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, predicted);
    send_block(KIND_DECRYPT, predicted.left_half, predicted.right_half, predicted);
    drain();

    // Round counts above the limit saturate, for the sum of decryption too.
    write_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 7'd65, 1'b0);
    send_block(KIND_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, predicted);
    send_block(KIND_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF, predicted);
    drain();
    write_settings(32'h0102_0304, 32'h0506_0708, 32'h090A_0B0C, 32'h0D0E_0F10, 7'd127, 1'b1);
    send_block(KIND_ENCRYPT, 32'h0000_0001, 32'h8000_0000, predicted);
    send_block(KIND_DECRYPT, 32'h8000_0000, 32'h0000_0001, predicted);
    drain();

    // Random phases. Each one draws new settings while the unit is idle and
    // then streams blocks; about a quarter of them decrypt the ciphertext of
    // the previous encryption, so round trips are exercised under every
    // setting. A few phases in the middle run without any idle cycles.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_idle <= (phase >= 8 && phase <= 10);
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_KEY_A, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_KEY_B, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_KEY_C, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_KEY_D, pick_word());
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_ROUNDS, {$urandom} << 7 | pick_rounds());
      if ($urandom_range(0, 3) != 0) write_reg(tea_pkg::CFG_BYTE_SWAP, $urandom);
      if ($urandom_range(0, 3) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                                              $urandom);
      cfg_we_i <= 1'b0;
      have_cipher = 1'b0;
      for (int n = 0; n < PHASE_BLOCKS; n++) begin
        if (have_cipher && $urandom_range(0, 99) < 25) begin
          send_block(KIND_DECRYPT, last_cipher.left_half, last_cipher.right_half, predicted);
          have_cipher = 1'b0;
        end else begin
          decrypt = $urandom_range(0, 1);
          send_block(decrypt, pick_word(), pick_word(), predicted);
          if (decrypt == KIND_ENCRYPT) begin
            last_cipher = predicted;
            have_cipher = 1'b1;
          end
        end
      end
      drain();
    end
    no_idle <= 1'b0;

    // Everything has arrived; give the unit one more block time to show any
    // stray result before the verdict.
    repeat (BLOCK_LATENCY) @(posedge clk_i);
    if (board.fault_count == 0 && board.pending() == 0) begin
      $display("tea_block_cipher_unit verification clean");
    end else begin
      $display("tea_block_cipher_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/tea_pkg.sv
sv/tea_ctrl.sv
sv/tea_datapath.sv
sv/tea_block_cipher_unit.sv
sim/tea_block_cipher_unit_tb.sv
